@@ rtl/core/vpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// vpcd_pkg
// Shared types and constants for the video port command block.
// ----------------------------------------------------------------------------
package vpcd_pkg;

    localparam int VRAM_WORDS_DEF = 32768;
    localparam int CRAM_WORDS_DEF = 64;

    localparam logic [2:0] PORT_DATA = 3'd0;
    localparam logic [2:0] PORT_CTRL = 3'd1;
    localparam logic [2:0] PORT_HV   = 3'd2;

    localparam logic [3:0] AT_VRAM_WR  = 4'd1;
    localparam logic [3:0] AT_CRAM_WR  = 4'd3;
    localparam logic [3:0] AT_VSRAM_WR = 4'd5;
    localparam logic [3:0] AT_VRAM_RD  = 4'd0;
    localparam logic [3:0] AT_CRAM_RD  = 4'd8;
    localparam logic [3:0] AT_VSRAM_RD = 4'd4;

    localparam logic [4:0] REG_MODE2   = 5'd1;
    localparam logic [4:0] REG_AUTOINC = 5'd15;
    localparam logic [4:0] REG_LEN_LO  = 5'd19;
    localparam logic [4:0] REG_LEN_HI  = 5'd20;
    localparam logic [4:0] REG_SRC_LO  = 5'd21;
    localparam logic [4:0] REG_SRC_MID = 5'd22;
    localparam logic [4:0] REG_SRC_HI  = 5'd23;

    localparam logic [15:0] STATUS_FIXED = 16'h3420;

    // item handed from the front part to the executing back part
    typedef struct packed {
        logic        mode;
        logic [2:0]  port;
        logic [15:0] wdata;
        logic [15:0] status;
        logic [9:0]  line;
        logic [11:0] cycles;
    } vpcd_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_COPY_RD,
        ST_COPY_WAIT,
        ST_COPY_WR,
        ST_FILL_LO_RD,
        ST_FILL_LO_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_OUT
    } vpcd_state_t;

endpackage

@@ rtl/core/video_port_command_dma_top.sv @@
// ----------------------------------------------------------------------------
// video_port_command_dma_top
// Data, control and HV-counter port of a tile video unit with fill and copy.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit up)
// s_axis    in   tuser: mode[0] port[3:1]
//                tdata: write_data[15:0] status_bits[31:16] scanline[41:32]
//                       cpu_cycles[53:42]
// m_axis    out  tdata: read_data[15:0]
// A plain access runs execute and output, a data read also a read wait; a data
// write with a pending command executes twice. A fill reads and writes each
// byte, a copy reads, waits and writes each word; a data write ending a copy
// command runs the copy first. Two items queue in front while the back part works.
// Reset is synchronous; memories hold no reset contents.
// ----------------------------------------------------------------------------
module video_port_command_dma_top
    import vpcd_pkg::*;
#(
    parameter int VRAM_WORDS = VRAM_WORDS_DEF,
    parameter int CRAM_WORDS = CRAM_WORDS_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [3:0]  s_axis_tuser,   // mode, port
    input  logic [55:0] s_axis_tdata,   // write_data, status_bits, scanline, cpu_cycles
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // read_data
);
    vpcd_cmd_t in_item, q_item;
    logic      q_valid, q_ready;

    assign in_item.mode   = s_axis_tuser[0];
    assign in_item.port   = s_axis_tuser[3:1];
    assign in_item.wdata  = s_axis_tdata[15:0];
    assign in_item.status = s_axis_tdata[31:16];
    assign in_item.line   = s_axis_tdata[41:32];
    assign in_item.cycles = s_axis_tdata[53:42];

    vpcd_queue u_queue (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    vpcd_exec #(.VRAM_WORDS(VRAM_WORDS), .CRAM_WORDS(CRAM_WORDS)) u_exec (
        .aclk, .aresetn,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_item),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(m_axis_tdata)
    );

endmodule

@@ rtl/core/vpcd_queue.sv @@
// ----------------------------------------------------------------------------
// vpcd_queue
// Two-entry item queue between the accepting front and the executing back.
// ----------------------------------------------------------------------------
module vpcd_queue
    import vpcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  vpcd_cmd_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output vpcd_cmd_t  out_item
);
    vpcd_cmd_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 && !pop |=> cnt_reg == 2'd2) else $error("queue lost item");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");

endmodule

@@ rtl/core/vpcd_exec.sv @@
// ----------------------------------------------------------------------------
// vpcd_exec
// Back part: runs port accesses, command decode, memories, fill and copy.
// ----------------------------------------------------------------------------
module vpcd_exec
    import vpcd_pkg::*;
#(
    parameter int VRAM_WORDS = VRAM_WORDS_DEF,
    parameter int CRAM_WORDS = CRAM_WORDS_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  vpcd_cmd_t   cmd,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [15:0] res_data
);
    localparam int VAW = $clog2(VRAM_WORDS);
    localparam int CAW = $clog2(CRAM_WORDS);

    logic [15:0] vram_mem [VRAM_WORDS];
    logic [15:0] cram_mem [CRAM_WORDS];
    logic [15:0] vsram_mem [64];

    logic [7:0]  regs_reg [32];
    logic [31:0] cmdw_reg;
    logic        pend_reg;
    logic [3:0]  atype_reg;
    logic [15:0] addr_reg;
    logic [7:0]  tog_reg;
    logic [15:0] len_reg;
    logic [31:0] src_reg;
    logic [15:0] out_reg;
    logic [15:0] vq_reg;
    logic [15:0] cq_reg;
    logic [15:0] sq_reg;
    logic [15:0] dat_reg;
    vpcd_cmd_t   cur_reg;
    vpcd_state_t state_reg, state_next;

    logic [VAW-1:0] vrd_idx;
    logic [VAW-1:0] vwr_idx;
    logic [15:0]    vwr_data;
    logic           vwr_en;
    logic [CAW-1:0] c_idx;
    logic [5:0]     s_idx;
    logic [15:0]    st_word;
    logic [31:0]    dcmd;
    logic [3:0]     dec_at;
    logic [15:0]    dec_addr;
    logic           dec_copy;
    logic           fill_ok;
    logic [15:0]    fill_addr;
    logic [7:0]     fill_byte;
    logic [15:0]    cur_len;
    logic [15:0]    status_w;
    logic [7:0]     hv_v;
    logic [11:0]    hdiff;

    // word index of the current access address
    assign c_idx = CAW'(addr_reg[15:1]);
    assign s_idx = addr_reg[6:1];
    assign st_word = addr_reg[0] ? {dat_reg[7:0], dat_reg[15:8]} : dat_reg;
    assign cur_len = {regs_reg[REG_LEN_HI], regs_reg[REG_LEN_LO]};
    assign fill_ok = cmdw_reg[7] && regs_reg[REG_MODE2][4]
                     && regs_reg[REG_SRC_HI][7:6] == 2'd2;

    function automatic logic [31:0] with_low(input logic [31:0] w, input logic [15:0] d);
        with_low = {w[31:16], d};
    endfunction

    // decode of a complete command word
    always_comb begin
        dcmd = (cur_reg.port == PORT_CTRL) ? with_low(cmdw_reg, cur_reg.wdata) : cmdw_reg;
        dec_at   = {dcmd[5:4], dcmd[31:30]};
        dec_addr = {dcmd[1:0], dcmd[29:16]};
        dec_copy = dcmd[7] && regs_reg[REG_MODE2][4] && regs_reg[REG_SRC_HI][7:6] == 2'd3;
    end

    assign fill_addr = (state_reg == ST_FILL_LO_RD || state_reg == ST_FILL_LO_WR)
                       ? (addr_reg ^ 16'h0001) : addr_reg;
    // low byte goes to the partner byte first, then the high byte is repeated
    assign fill_byte = (state_reg == ST_FILL_LO_RD || state_reg == ST_FILL_LO_WR)
                       ? dat_reg[7:0] : dat_reg[15:8];

    always_comb begin
        vrd_idx = VAW'(addr_reg[15:1]);
        case (state_reg)
            ST_COPY_RD:                   vrd_idx = VAW'(src_reg[14:0]);
            ST_FILL_LO_RD, ST_FILL_RD:    vrd_idx = VAW'(fill_addr[15:1]);
            default:                      vrd_idx = VAW'(addr_reg[15:1]);
        endcase
    end

    always_comb begin
        vwr_en   = 1'b0;
        vwr_idx  = VAW'(addr_reg[15:1]);
        vwr_data = st_word;
        case (state_reg)
            ST_EXEC: vwr_en = cur_reg.mode && cur_reg.port == PORT_DATA
                              && !pend_reg && !fill_ok && atype_reg == AT_VRAM_WR;
            ST_COPY_WR: vwr_en = (atype_reg == AT_VRAM_WR);
            ST_FILL_LO_WR, ST_FILL_WR: begin
                vwr_en  = 1'b1;
                vwr_idx = VAW'(fill_addr[15:1]);
                if (fill_addr[0]) vwr_data = {fill_byte, vq_reg[7:0]};
                else              vwr_data = {vq_reg[15:8], fill_byte};
            end
            default: vwr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        vq_reg <= vram_mem[vrd_idx];
        cq_reg <= cram_mem[c_idx];
        sq_reg <= vsram_mem[s_idx];
        if (vwr_en) vram_mem[vwr_idx] <= vwr_data;
        if ((state_reg == ST_COPY_WR || (state_reg == ST_EXEC && cur_reg.mode
             && cur_reg.port == PORT_DATA && !pend_reg && !fill_ok))
            && atype_reg == AT_CRAM_WR) cram_mem[c_idx] <= st_word;
        if ((state_reg == ST_COPY_WR || (state_reg == ST_EXEC && cur_reg.mode
             && cur_reg.port == PORT_DATA && !pend_reg && !fill_ok))
            && atype_reg == AT_VSRAM_WR) vsram_mem[s_idx] <= st_word;
    end

    always_comb begin
        status_w = cur_reg.status | STATUS_FIXED | (tog_reg[2] ? 16'h0100 : 16'h0200)
                   | (tog_reg[1] ? 16'h0004 : 16'h0000);
        hv_v  = ($signed(cur_reg.line) > -10'sd100) ? cur_reg.line[7:0] : tog_reg;
        hdiff = 12'd500 - cur_reg.cycles;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd_valid) state_next = ST_EXEC;
            ST_EXEC: begin
                state_next = ST_OUT;
                if (cur_reg.mode && cur_reg.port == PORT_DATA) begin
                    if (pend_reg) begin
                        state_next = (dec_copy && cur_len[15:1] != 15'd0)
                                     ? ST_COPY_RD : ST_EXEC;
                    end else if (fill_ok) begin
                        state_next = ST_FILL_LO_RD;
                    end
                end else if (cur_reg.mode && cur_reg.port == PORT_CTRL && pend_reg
                             && dec_copy && cur_len[15:1] != 15'd0) begin
                    state_next = ST_COPY_RD;
                end else if (!cur_reg.mode && cur_reg.port == PORT_DATA) begin
                    state_next = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT:    state_next = ST_OUT;
            ST_COPY_RD:    state_next = ST_COPY_WAIT;
            ST_COPY_WAIT:  state_next = ST_COPY_WR;
            // a data write that started the copy still has its own write to do
            ST_COPY_WR:    state_next = (len_reg != 16'd1) ? ST_COPY_RD :
                                        (cur_reg.port == PORT_DATA) ? ST_EXEC : ST_OUT;
            ST_FILL_LO_RD: state_next = ST_FILL_LO_WR;
            ST_FILL_LO_WR: state_next = (cur_len == 16'd0) ? ST_OUT : ST_FILL_RD;
            ST_FILL_RD:    state_next = ST_FILL_WR;
            ST_FILL_WR:    state_next = (len_reg == 16'd1) ? ST_OUT : ST_FILL_RD;
            ST_OUT:        if (res_ready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_OUT);
        res_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && cmd_valid) begin
            cur_reg <= cmd;
            dat_reg <= cmd.wdata;
        end
        if (state_reg == ST_COPY_WAIT) dat_reg <= vq_reg;
        // restore the item's word once the copy is done
        if (state_reg == ST_COPY_WR && len_reg == 16'd1) dat_reg <= cur_reg.wdata;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 32; i++) regs_reg[i] <= 8'd0;
            cmdw_reg  <= 32'd0;
            pend_reg  <= 1'b0;
            atype_reg <= 4'd0;
            addr_reg  <= 16'd0;
            tog_reg   <= 8'd0;
            len_reg   <= 16'd0;
            src_reg   <= 32'd0;
            out_reg   <= 16'd0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_EXEC: begin
                    out_reg <= 16'd0;
                    if (cur_reg.mode && cur_reg.port == PORT_DATA) begin
                        if (pend_reg) begin
                            // decode the latched command, then redo this item
                            pend_reg  <= 1'b0;
                            atype_reg <= dec_at;
                            addr_reg  <= dec_addr;
                            len_reg   <= {1'b0, cur_len[15:1]};
                            src_reg   <= {7'd0, regs_reg[REG_SRC_HI], 17'd0}
                                         | {15'd0, regs_reg[REG_SRC_MID], 9'd0}
                                         | {23'd0, regs_reg[REG_SRC_LO], 1'b0};
                        end else if (fill_ok) begin
                            len_reg <= cur_len;
                        end else begin
                            addr_reg <= addr_reg + {8'd0, regs_reg[REG_AUTOINC]};
                        end
                    end else if (cur_reg.mode && cur_reg.port == PORT_CTRL) begin
                        if (pend_reg) begin
                            cmdw_reg  <= dcmd;
                            pend_reg  <= 1'b0;
                            atype_reg <= dec_at;
                            addr_reg  <= dec_addr;
                            len_reg   <= {1'b0, cur_len[15:1]};
                            src_reg   <= {7'd0, regs_reg[REG_SRC_HI], 17'd0}
                                         | {15'd0, regs_reg[REG_SRC_MID], 9'd0}
                                         | {23'd0, regs_reg[REG_SRC_LO], 1'b0};
                        end else if (cur_reg.wdata[15:14] == 2'b10) begin
                            regs_reg[cur_reg.wdata[12:8]] <= cur_reg.wdata[7:0];
                        end else begin
                            cmdw_reg <= {cur_reg.wdata, cmdw_reg[15:0]};
                            pend_reg <= 1'b1;
                        end
                    end else if (!cur_reg.mode && cur_reg.port == PORT_CTRL) begin
                        out_reg <= status_w;
                        tog_reg <= tog_reg + 8'd1;
                    end else if (!cur_reg.mode && cur_reg.port == PORT_HV) begin
                        out_reg <= {hv_v, hdiff[8:1]};
                        if (!($signed(cur_reg.line) > -10'sd100)) tog_reg <= tog_reg + 8'd1;
                    end
                end
                ST_RD_WAIT: begin
                    case (atype_reg)
                        AT_VRAM_RD:  out_reg <= vq_reg;
                        AT_CRAM_RD:  out_reg <= cq_reg;
                        AT_VSRAM_RD: out_reg <= sq_reg;
                        default:     out_reg <= 16'd0;
                    endcase
                    addr_reg <= addr_reg + {8'd0, regs_reg[REG_AUTOINC]};
                end
                ST_COPY_WR: begin
                    addr_reg <= addr_reg + {8'd0, regs_reg[REG_AUTOINC]};
                    src_reg  <= src_reg + 32'd2;
                    len_reg  <= len_reg - 16'd1;
                end
                ST_FILL_WR: begin
                    addr_reg <= addr_reg + {8'd0, regs_reg[REG_AUTOINC]};
                    len_reg  <= len_reg - 16'd1;
                end
                default: ;
            endcase
        end
    end

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !cmd_ready) else $error("accepted while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result dropped");
    a_copy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COPY_WR |-> len_reg != 16'd0) else $error("copy length underflow");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the video port command block: every bus access is
// predicted in order by a port model that tracks the memories, registers,
// command latch and toggle counter; each returned word is compared with the
// oldest predicted word. Memories are swept full first, so later reads and
// copies see only written entries.
// ----------------------------------------------------------------------------
module tb_top;
    import vpcd_pkg::*;

    localparam int RUN_LIMIT = 4000000;

    typedef struct packed {
        logic        mode;
        logic [2:0]  port;
        logic [15:0] wdata;
        logic [15:0] status;
        logic [9:0]  line;
        logic [11:0] cycles;
    } bus_access_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [3:0]  s_axis_tuser = '0;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    video_port_command_dma_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // port model state
    logic [15:0] pm_vram [VRAM_WORDS_DEF];
    logic [15:0] pm_cram [64];
    logic [15:0] pm_vsram [64];
    logic [7:0]  pm_regs [32];
    logic [31:0] pm_cmd;
    logic        pm_pending;
    logic [3:0]  pm_atype;
    logic [15:0] pm_addr;
    logic [7:0]  pm_toggle;

    logic [63:0] access_q [$];
    logic [15:0] read_word_q [$];
    int          sweep_count;
    int          sent_count;
    int          read_count;
    int          error_count;
    int          cycle_count;
    int          hold_count;
    bit          hold_done;
    logic        s_fire;

    function automatic void pm_step_addr();
        pm_addr = pm_addr + 16'(pm_regs[REG_AUTOINC]);
    endfunction

    function automatic void pm_store_word(input logic [15:0] value);
        logic [15:0] w;
        logic [14:0] idx;
        w   = pm_addr[0] ? {value[7:0], value[15:8]} : value;
        idx = pm_addr[15:1];
        case (pm_atype)
            AT_VRAM_WR:  pm_vram[idx] = w;
            AT_CRAM_WR:  pm_cram[idx[5:0]] = w;
            AT_VSRAM_WR: pm_vsram[idx[5:0]] = w;
            default: ;
        endcase
        pm_step_addr();
    endfunction

    function automatic void pm_put_byte(input logic [15:0] byte_addr, input logic [7:0] v);
        if (byte_addr[0]) pm_vram[byte_addr[15:1]][15:8] = v;
        else pm_vram[byte_addr[15:1]][7:0] = v;
    endfunction

    function automatic void pm_decode();
        logic [31:0] src;
        logic [15:0] len;
        pm_atype = {pm_cmd[5:4], pm_cmd[31:30]};
        pm_addr  = {pm_cmd[1:0], pm_cmd[29:16]};
        if (pm_cmd[7] && pm_regs[REG_MODE2][4] && pm_regs[REG_SRC_HI][7:6] == 2'd3) begin
            src = (32'(pm_regs[REG_SRC_LO]) << 1) | (32'(pm_regs[REG_SRC_MID]) << 9) |
                  (32'(pm_regs[REG_SRC_HI]) << 17);
            len = {pm_regs[REG_LEN_HI], pm_regs[REG_LEN_LO]} >> 1;
            for (int i = 0; i < len; i++) begin
                pm_store_word(pm_vram[src[14:0]]);
                src = src + 2;
            end
        end
    endfunction

    // advance the model by one access and return the word it reads back
    function automatic logic [15:0] pm_access(input bus_access_t a);
        logic [15:0] r;
        logic [15:0] len;
        logic [31:0] t;
        logic [7:0]  v;
        r = '0;
        if (a.mode) begin
            if (a.port == PORT_DATA) begin
                if (pm_pending) pm_decode();
                pm_pending = 1'b0;
                if (pm_cmd[7] && pm_regs[REG_MODE2][4] &&
                    pm_regs[REG_SRC_HI][7:6] == 2'd2) begin
                    len = {pm_regs[REG_LEN_HI], pm_regs[REG_LEN_LO]};
                    pm_put_byte(pm_addr ^ 16'd1, a.wdata[7:0]);
                    for (int i = 0; i < len; i++) begin
                        pm_put_byte(pm_addr, a.wdata[15:8]);
                        pm_step_addr();
                    end
                end else begin
                    pm_store_word(a.wdata);
                end
            end else if (a.port == PORT_CTRL) begin
                if (pm_pending) begin
                    pm_cmd[15:0] = a.wdata;
                    pm_pending = 1'b0;
                    pm_decode();
                end else if (a.wdata[15:14] == 2'b10) begin
                    pm_regs[a.wdata[12:8]] = a.wdata[7:0];
                end else begin
                    pm_cmd[31:16] = a.wdata;
                    pm_pending = 1'b1;
                end
            end
        end else begin
            if (a.port == PORT_DATA) begin
                case (pm_atype)
                    AT_VRAM_RD:  r = pm_vram[pm_addr[15:1]];
                    AT_CRAM_RD:  r = pm_cram[pm_addr[6:1]];
                    AT_VSRAM_RD: r = pm_vsram[pm_addr[6:1]];
                    default: ;
                endcase
                pm_step_addr();
            end else if (a.port == PORT_CTRL) begin
                r = a.status | STATUS_FIXED | (pm_toggle[2] ? 16'h0100 : 16'h0200);
                if (pm_toggle[1]) r = r | 16'h0004;
                pm_toggle = pm_toggle + 8'd1;
            end else if (a.port == PORT_HV) begin
                if ($signed(a.line) > -100) begin
                    v = a.line[7:0];
                end else begin
                    v = pm_toggle;
                    pm_toggle = pm_toggle + 8'd1;
                end
                t = 32'd500 - 32'(a.cycles);
                r = {v, t[8:1]};
            end
        end
        return r;
    endfunction

    task automatic queue_access(input logic mode, input logic [2:0] port,
                                input logic [15:0] wdata);
        bus_access_t a;
        a.mode   = mode;
        a.port   = port;
        a.wdata  = wdata;
        a.status = 16'($urandom);
        a.line   = 10'($urandom);
        a.cycles = 12'($urandom);
        read_word_q.push_back(pm_access(a));
        access_q.push_back({6'b0, a.cycles, a.line, a.status, a.wdata, a.port, a.mode});
    endtask

    task automatic queue_hv(input logic [9:0] line, input logic [11:0] cycles);
        bus_access_t a;
        a.mode   = 1'b0;
        a.port   = PORT_HV;
        a.wdata  = 16'($urandom);
        a.status = 16'($urandom);
        a.line   = line;
        a.cycles = cycles;
        read_word_q.push_back(pm_access(a));
        access_q.push_back({6'b0, a.cycles, a.line, a.status, a.wdata, a.port, a.mode});
    endtask

    task automatic queue_reg(input logic [4:0] idx, input logic [7:0] val);
        queue_access(1'b1, PORT_CTRL, {3'b100, idx, val});
    endtask

    // two-word command: access type, address, DMA bit
    task automatic queue_command(input logic [3:0] at, input logic [15:0] addr,
                                 input logic dma);
        queue_access(1'b1, PORT_CTRL, {at[1:0], addr[13:0]});
        queue_access(1'b1, PORT_CTRL, {8'd0, 8'(16'($urandom)) & 8'h40 | {dma, 7'b0} |
                                       {2'b0, at[3:2], 2'b0, addr[15:14]}});
    endtask

    function automatic logic [3:0] any_access_type();
        logic [3:0] list [6];
        list = '{AT_VRAM_WR, AT_CRAM_WR, AT_VSRAM_WR, AT_VRAM_RD, AT_CRAM_RD, AT_VSRAM_RD};
        if ($urandom_range(0, 9) == 0) return 4'($urandom);
        return list[$urandom_range(0, 5)];
    endfunction

    // stimulus and end of run
    initial begin
        logic [4:0] ridx;
        logic [7:0] rval;
        pm_cmd = '0; pm_pending = 1'b0; pm_atype = '0; pm_addr = '0; pm_toggle = '0;
        foreach (pm_regs[i]) pm_regs[i] = '0;
        error_count = 0;

        // fill every memory so later reads and DMA only see written words:
        // one byte fill from byte 1 covers all of video RAM
        queue_reg(REG_MODE2, 8'h10);
        queue_reg(REG_AUTOINC, 8'd1);
        queue_reg(REG_LEN_LO, 8'hff);
        queue_reg(REG_LEN_HI, 8'hff);
        queue_reg(REG_SRC_HI, 8'h80);
        queue_command(AT_VRAM_WR, 16'h0001, 1'b1);
        queue_access(1'b1, PORT_DATA, 16'($urandom));
        queue_reg(REG_AUTOINC, 8'd2);
        queue_command(AT_CRAM_WR, 16'h0000, 1'b0);
        for (int i = 0; i < 64; i++) queue_access(1'b1, PORT_DATA, 16'($urandom));
        queue_command(AT_VSRAM_WR, 16'h0000, 1'b0);
        for (int i = 0; i < 64; i++) queue_access(1'b1, PORT_DATA, 16'($urandom));
        sweep_count = access_q.size();

        // directed corners
        queue_hv(10'h380, 12'd0);
        queue_hv(10'h39c, 12'd4095);
        queue_hv(10'h39d, 12'd500);
        queue_hv(10'h1ff, 12'd501);
        for (int i = 0; i < 8; i++) queue_access(1'b0, PORT_CTRL, 16'hffff);
        queue_access(1'b1, 3'd7, 16'hffff);
        queue_access(1'b0, 3'd3, 16'h0000);
        queue_command(AT_VRAM_WR, 16'hffff, 1'b0);
        queue_access(1'b1, PORT_DATA, 16'h12ab);
        queue_command(AT_VRAM_RD, 16'hfffe, 1'b0);
        queue_access(1'b0, PORT_DATA, 16'h0);
        queue_command(AT_CRAM_RD, 16'h007e, 1'b0);
        queue_access(1'b0, PORT_DATA, 16'h0);
        queue_command(AT_VSRAM_RD, 16'h0001, 1'b0);
        queue_access(1'b0, PORT_DATA, 16'h0);
        // data write with the command still half latched
        queue_access(1'b1, PORT_CTRL, {AT_VRAM_WR[1:0], 14'h0100});
        queue_access(1'b1, PORT_DATA, 16'h5a5a);
        // longest fill, then longest copy
        queue_reg(REG_MODE2, 8'hff);
        queue_reg(REG_LEN_LO, 8'hff);
        queue_reg(REG_LEN_HI, 8'hff);
        queue_reg(REG_SRC_HI, 8'h80);
        queue_command(AT_VRAM_WR, 16'h0000, 1'b1);
        queue_access(1'b1, PORT_DATA, 16'hc3e1);
        queue_reg(REG_SRC_LO, 8'hff);
        queue_reg(REG_SRC_MID, 8'hff);
        queue_reg(REG_SRC_HI, 8'hff);
        queue_command(AT_VRAM_WR, 16'h4001, 1'b1);
        queue_reg(REG_LEN_HI, 8'h00);
        queue_reg(REG_AUTOINC, 8'hff);

        // random accesses, mostly well-formed command/data sequences
        for (int n = 0; n < 310; n++) begin
            case ($urandom_range(0, 11))
                0, 1: begin
                    ridx = 5'($urandom);
                    if ($urandom_range(0, 1)) begin
                        ridx = ($urandom_range(0, 1)) ? REG_AUTOINC
                               : REG_SRC_HI - 5'($urandom_range(0, 4));
                    end
                    rval = 8'($urandom);
                    if (ridx == REG_LEN_HI) rval = 8'($urandom_range(0, 1));
                    if (ridx == REG_LEN_LO) rval = 8'($urandom_range(0, 20));
                    if (ridx == REG_AUTOINC && $urandom_range(0, 2) != 0)
                        rval = 8'($urandom_range(0, 4));
                    queue_reg(ridx, rval);
                end
                2, 3: queue_command(any_access_type(), 16'($urandom),
                                    $urandom_range(0, 3) == 0);
                4, 5: queue_access(1'b1, PORT_DATA, 16'($urandom));
                6, 7: queue_access(1'b0, PORT_DATA, 16'($urandom));
                8: queue_access(1'b0, PORT_CTRL, 16'($urandom));
                9: queue_access(1'b0, PORT_HV, 16'($urandom));
                10: queue_access(1'($urandom), 3'($urandom_range(3, 7)), 16'($urandom));
                default: queue_access(1'b1, PORT_CTRL, 16'($urandom));
            endcase
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (access_q.size() != 0 || read_word_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d accesses after a full memory sweep, %0d words read back,",
                 sent_count, read_count);
        $display("including longest fill and copy and a long output stall.");
        if (error_count == 0) begin
            $display("[video_port_command_dma_top] OK");
        end else begin
            $display("[video_port_command_dma_top] ERROR");
        end
        $finish;
    end

    function automatic int idle_phase();
        if (sent_count < sweep_count) return (sent_count / 1000) % 3;
        return ((sent_count - sweep_count) / 140) % 3;
    endfunction

    // driver: hold the item until accepted, then maybe idle
    always @(negedge aclk) begin
        logic [63:0] item;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (access_q.size() != 0 &&
                !(idle_phase() == 0 && $urandom_range(0, 99) < 18) &&
                !(idle_phase() == 1 && $urandom_range(0, 99) < 60)) begin
                item = access_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= item[3:0];
                s_axis_tdata  <= item[59:4];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off early in the run
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (hold_count > 0) begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count - 1;
        end else if (!hold_done && read_count == 20) begin
            m_axis_tready <= 1'b0;
            hold_count <= 400;
            hold_done  <= 1'b1;
        end else begin
            m_axis_tready <= !((idle_phase() == 0 && $urandom_range(0, 99) < 60) ||
                               (idle_phase() == 1 && $urandom_range(0, 99) < 18));
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        logic [15:0] want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("[video_port_command_dma_top] ERROR");
            $finish;
        end
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) sent_count <= sent_count + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            read_count <= read_count + 1;
            if (read_word_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
                error_count <= error_count + 1;
            end else begin
                want = read_word_q.pop_front();
                if (m_axis_tdata !== want) begin
                    $display("%0t: read_data mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        sent_count  = 0;
        read_count  = 0;
        s_fire      = 1'b0;
    end

endmodule
